### rtl/tml_pkg.sv
// Package for the triplet margin loss block.
// Holds codes, limits, controller states and the control/status structs.
// No dependencies.
package tml_pkg;

    localparam int MAX_ORDER       = 4;
    localparam int MAX_BATCH       = 65535;
    localparam int DEFAULT_MAX_DIM = 1024;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_MARGIN = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORDER  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EPS    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SWAP   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BATCH  = 3'd6;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_MEAN = 2'd1;

    localparam logic [31:0] RST_MARGIN = 32'd65536;
    localparam logic [2:0]  RST_ORDER  = 3'd2;
    localparam logic [15:0] RST_EPS    = 16'd0;
    localparam logic [1:0]  RST_MODE   = MODE_MEAN;
    localparam logic [10:0] RST_DIM    = 11'd1;
    localparam logic [15:0] RST_BATCH  = 16'd1;

    localparam logic [55:0] DIST_CAP  = {56{1'b1}};
    localparam logic [47:0] TOTAL_CAP = {48{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_PW,
        S_ACC,
        S_DINIT,
        S_LIN,
        S_RSQ,
        S_RPW,
        S_RCMP,
        S_DNEXT,
        S_LOSS,
        S_TOTAL,
        S_ROUTE,
        S_DIVINIT,
        S_DIV,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_PW,
        OP_ACC,
        OP_DINIT,
        OP_LIN,
        OP_RSQ,
        OP_RPW,
        OP_RCMP,
        OP_DNEXT,
        OP_LOSS,
        OP_TOTAL,
        OP_ADV,
        OP_DIVINIT,
        OP_DIVSTEP
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic row_end;
        logic order_one;
        logic bit_zero;
        logic sel_last;
        logic last_row;
        logic mode_none;
        logic mode_mean;
        logic div_done;
        logic out_free;
    } dp_status_t;

endpackage

### rtl/triplet_margin_loss_top.sv
// Top level of the triplet margin loss block.
// Each element is accepted, squared, raised to the power p and accumulated
// before the next is taken. At row end each of the three distances takes a
// linear step for p = 1 or a root search for p >= 2 (32, 22 or 16 root bits
// for p = 2, 3, 4) by the shared bit-serial root unit. Loss and total come
// next, then a mean by the one-bit-per-cycle divider, then the emit step.
// A result waits in the output register while the next elements are taken.
// Depends on tml_pkg, tml_ctrl and tml_datapath.
module triplet_margin_loss_top
#(
    parameter int MAX_DIM = tml_pkg::DEFAULT_MAX_DIM
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tml_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tml_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [15:0]                  anchor_value,
    input  logic signed [15:0]                  positive_value,
    input  logic signed [15:0]                  negative_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [31:0]                         loss_value,
    output logic [15:0]                         row_index,
    output logic                                batch_done
);

    tml_pkg::dp_cmd_t    cmd;
    tml_pkg::dp_status_t status;

    tml_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tml_datapath
    #(
        .MAX_DIM (MAX_DIM)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .anchor_value   (anchor_value),
        .positive_value (positive_value),
        .negative_value (negative_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .loss_value     (loss_value),
        .row_index      (row_index),
        .batch_done     (batch_done),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

### rtl/tml_ctrl.sv
// Controller state machine for the triplet margin loss block.
// Sequences element, distance, loss, division and emit steps of tml_datapath.
// Depends on tml_pkg.
module tml_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tml_pkg::dp_status_t status,
    output tml_pkg::dp_cmd_t    cmd
);

    tml_pkg::state_t state_reg;
    tml_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tml_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tml_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tml_pkg::S_SQ;
                end
            end
            tml_pkg::S_SQ:    state_next = tml_pkg::S_PW;
            tml_pkg::S_PW:    state_next = tml_pkg::S_ACC;
            tml_pkg::S_ACC:
            begin
                state_next = status.row_end ? tml_pkg::S_DINIT : tml_pkg::S_IDLE;
            end
            tml_pkg::S_DINIT:
            begin
                state_next = status.order_one ? tml_pkg::S_LIN : tml_pkg::S_RSQ;
            end
            tml_pkg::S_LIN:   state_next = tml_pkg::S_DNEXT;
            tml_pkg::S_RSQ:   state_next = tml_pkg::S_RPW;
            tml_pkg::S_RPW:   state_next = tml_pkg::S_RCMP;
            tml_pkg::S_RCMP:
            begin
                state_next = status.bit_zero ? tml_pkg::S_DNEXT : tml_pkg::S_RSQ;
            end
            tml_pkg::S_DNEXT:
            begin
                state_next = status.sel_last ? tml_pkg::S_LOSS : tml_pkg::S_DINIT;
            end
            tml_pkg::S_LOSS:  state_next = tml_pkg::S_TOTAL;
            tml_pkg::S_TOTAL: state_next = tml_pkg::S_ROUTE;
            tml_pkg::S_ROUTE:
            begin
                if (status.mode_none)
                begin
                    state_next = tml_pkg::S_EMIT;
                end
                else if (!status.last_row)
                begin
                    state_next = tml_pkg::S_IDLE;
                end
                else if (status.mode_mean)
                begin
                    state_next = tml_pkg::S_DIVINIT;
                end
                else
                begin
                    state_next = tml_pkg::S_EMIT;
                end
            end
            tml_pkg::S_DIVINIT: state_next = tml_pkg::S_DIV;
            tml_pkg::S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = tml_pkg::S_EMIT;
                end
            end
            tml_pkg::S_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = tml_pkg::S_IDLE;
                end
            end
            default: state_next = tml_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = tml_pkg::OP_NONE;
        cmd.emit = 1'b0;
        in_stall = 1'b1;
        case (state_reg)
            tml_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = tml_pkg::OP_LOAD;
                end
            end
            tml_pkg::S_SQ:    cmd.op = tml_pkg::OP_SQ;
            tml_pkg::S_PW:    cmd.op = tml_pkg::OP_PW;
            tml_pkg::S_ACC:   cmd.op = tml_pkg::OP_ACC;
            tml_pkg::S_DINIT: cmd.op = tml_pkg::OP_DINIT;
            tml_pkg::S_LIN:   cmd.op = tml_pkg::OP_LIN;
            tml_pkg::S_RSQ:   cmd.op = tml_pkg::OP_RSQ;
            tml_pkg::S_RPW:   cmd.op = tml_pkg::OP_RPW;
            tml_pkg::S_RCMP:  cmd.op = tml_pkg::OP_RCMP;
            tml_pkg::S_DNEXT: cmd.op = tml_pkg::OP_DNEXT;
            tml_pkg::S_LOSS:  cmd.op = tml_pkg::OP_LOSS;
            tml_pkg::S_TOTAL: cmd.op = tml_pkg::OP_TOTAL;
            tml_pkg::S_ROUTE:
            begin
                if (!status.mode_none && !status.last_row)
                begin
                    cmd.op = tml_pkg::OP_ADV;
                end
            end
            tml_pkg::S_DIVINIT: cmd.op = tml_pkg::OP_DIVINIT;
            tml_pkg::S_DIV:     cmd.op = tml_pkg::OP_DIVSTEP;
            tml_pkg::S_EMIT:    cmd.emit = status.out_free;
            default:            cmd.op = tml_pkg::OP_NONE;
        endcase
    end

endmodule

### rtl/tml_datapath.sv
// Datapath for the triplet margin loss block: config registers, power lanes,
// shared root unit, loss and batch total, mean divider and output register.
// Depends on tml_pkg.
module tml_datapath
#(
    parameter int MAX_DIM = tml_pkg::DEFAULT_MAX_DIM
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [tml_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tml_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic signed [15:0]                  anchor_value,
    input  logic signed [15:0]                  positive_value,
    input  logic signed [15:0]                  negative_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [31:0]                         loss_value,
    output logic [15:0]                         row_index,
    output logic                                batch_done,
    input  tml_pkg::dp_cmd_t                    cmd,
    output tml_pkg::dp_status_t                 status
);

    localparam int EC_W = $clog2(MAX_DIM + 1);

    logic signed [31:0] margin_reg;
    logic [2:0]         order_reg;
    logic [15:0]        eps_reg;
    logic               swap_reg;
    logic [1:0]         mode_reg;
    logic [10:0]        dim_reg;
    logic [15:0]        batch_reg;

    logic [2:0]  p_eff;
    logic [31:0] dim_eff;
    logic [15:0] nb_eff;

    logic [15:0] mag_reg [3];
    logic [31:0] sq_reg  [3];
    logic [63:0] pw_reg  [3];
    logic [63:0] sum_reg [3];
    logic [15:0] mag_next [3];
    logic [63:0] pw_next  [3];
    logic [63:0] sum_next [3];

    logic [EC_W-1:0] elem_reg;
    logic [15:0]     row_reg;

    logic [1:0]  sel_reg;
    logic [63:0] x_reg;
    logic [31:0] r_reg;
    logic [4:0]  bit_reg;
    logic [63:0] rsq_reg;
    logic [65:0] rpw_reg;
    logic [55:0] dist_reg [3];

    logic [31:0] cand;
    logic [63:0] sel_sum;
    logic [64:0] x_sum;
    logic [63:0] eps_shift;
    logic [4:0]  bit_start;
    logic [56:0] lin_val;
    logic [55:0] lin_dist;

    logic [56:0] loss_reg;
    logic [47:0] total_reg;
    logic        last_reg;
    logic [55:0] dn_eff;
    logic signed [57:0] loss_raw;
    logic [57:0] total_sum;

    logic [47:0] quo_reg;
    logic [15:0] rem_reg;
    logic [5:0]  div_cnt_reg;
    logic [16:0] trial;

    logic        out_valid_reg;
    logic [31:0] loss_out_reg;
    logic [15:0] row_out_reg;
    logic        done_out_reg;
    logic [31:0] emit_value;

    always_comb
    begin
        if (order_reg == 3'd0)
        begin
            p_eff = 3'd1;
        end
        else if (32'(order_reg) > tml_pkg::MAX_ORDER)
        begin
            p_eff = 3'(tml_pkg::MAX_ORDER);
        end
        else
        begin
            p_eff = order_reg;
        end

        if (dim_reg == 11'd0)
        begin
            dim_eff = 32'd1;
        end
        else if (32'(dim_reg) > 32'(MAX_DIM))
        begin
            dim_eff = 32'(MAX_DIM);
        end
        else
        begin
            dim_eff = 32'(dim_reg);
        end

        if (batch_reg == 16'd0)
        begin
            nb_eff = 16'd1;
        end
        else if (32'(batch_reg) > tml_pkg::MAX_BATCH)
        begin
            nb_eff = 16'(tml_pkg::MAX_BATCH);
        end
        else
        begin
            nb_eff = batch_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            margin_reg <= tml_pkg::RST_MARGIN;
            order_reg  <= tml_pkg::RST_ORDER;
            eps_reg    <= tml_pkg::RST_EPS;
            swap_reg   <= 1'b0;
            mode_reg   <= tml_pkg::RST_MODE;
            dim_reg    <= tml_pkg::RST_DIM;
            batch_reg  <= tml_pkg::RST_BATCH;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tml_pkg::REG_MARGIN: margin_reg <= cfg_data;
                tml_pkg::REG_ORDER:  order_reg  <= cfg_data[2:0];
                tml_pkg::REG_EPS:    eps_reg    <= cfg_data[15:0];
                tml_pkg::REG_SWAP:   swap_reg   <= cfg_data[0];
                tml_pkg::REG_MODE:   mode_reg   <= cfg_data[1:0];
                tml_pkg::REG_DIM:    dim_reg    <= cfg_data[10:0];
                tml_pkg::REG_BATCH:  batch_reg  <= cfg_data[15:0];
                default:             margin_reg <= margin_reg;
            endcase
        end
    end

    // absolute differences, powers and saturating sums per lane
    always_comb
    begin
        logic signed [16:0] d0;
        logic signed [16:0] d1;
        logic signed [16:0] d2;
        logic [64:0]        s;
        d0 = 17'(anchor_value) - 17'(positive_value);
        d1 = 17'(anchor_value) - 17'(negative_value);
        d2 = 17'(positive_value) - 17'(negative_value);
        mag_next[0] = d0[16] ? 16'(-d0) : d0[15:0];
        mag_next[1] = d1[16] ? 16'(-d1) : d1[15:0];
        mag_next[2] = d2[16] ? 16'(-d2) : d2[15:0];
        for (int i = 0; i < 3; i++)
        begin
            case (p_eff)
                3'd1:    pw_next[i] = 64'(mag_reg[i]);
                3'd2:    pw_next[i] = 64'(sq_reg[i]);
                3'd3:    pw_next[i] = 64'(sq_reg[i] * 48'(mag_reg[i]));
                default: pw_next[i] = 64'(sq_reg[i]) * 64'(sq_reg[i]);
            endcase
            s = {1'b0, sum_reg[i]} + {1'b0, pw_reg[i]};
            sum_next[i] = s[64] ? {64{1'b1}} : s[63:0];
        end
    end

    // root unit operands
    always_comb
    begin
        cand    = r_reg | (32'd1 << bit_reg);
        sel_sum = sum_reg[sel_reg];
        case (p_eff)
            3'd3:
            begin
                eps_shift = 64'(eps_reg) << 8;
                bit_start = 5'd21;
            end
            3'd4:
            begin
                eps_shift = 64'(eps_reg) << 16;
                bit_start = 5'd15;
            end
            default:
            begin
                eps_shift = 64'(eps_reg);
                bit_start = 5'd31;
            end
        endcase
        x_sum   = {1'b0, sel_sum} + {1'b0, eps_shift};
        lin_val = {1'b0, sel_sum[47:0], 8'd0} + 57'(eps_reg);
        if (sel_sum[63:48] != 16'd0 || lin_val[56])
        begin
            lin_dist = tml_pkg::DIST_CAP;
        end
        else
        begin
            lin_dist = lin_val[55:0];
        end
    end

    // loss, total and divider trial
    always_comb
    begin
        dn_eff = (swap_reg && (dist_reg[2] < dist_reg[1])) ? dist_reg[2] : dist_reg[1];
        loss_raw = $signed({2'b00, dist_reg[0]}) - $signed({2'b00, dn_eff})
                   + 58'(margin_reg);
        total_sum = 58'(total_reg) + 58'(loss_reg);
        trial = {rem_reg, quo_reg[47]};
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tml_pkg::OP_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= mag_next[i];
                end
            end
            tml_pkg::OP_SQ:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[i] <= 32'(mag_reg[i]) * 32'(mag_reg[i]);
                end
            end
            tml_pkg::OP_PW:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    pw_reg[i] <= pw_next[i];
                end
            end
            tml_pkg::OP_DINIT:
            begin
                x_reg   <= x_sum[64] ? {64{1'b1}} : x_sum[63:0];
                r_reg   <= 32'd0;
                bit_reg <= bit_start;
            end
            tml_pkg::OP_LIN:
            begin
                dist_reg[sel_reg] <= lin_dist;
            end
            tml_pkg::OP_RSQ:
            begin
                rsq_reg <= 64'(cand) * 64'(cand);
            end
            tml_pkg::OP_RPW:
            begin
                case (p_eff)
                    3'd3:    rpw_reg <= 66'(rsq_reg[43:0]) * 66'(cand[21:0]);
                    3'd4:    rpw_reg <= 66'(rsq_reg[31:0]) * 66'(rsq_reg[31:0]);
                    default: rpw_reg <= 66'(rsq_reg);
                endcase
            end
            tml_pkg::OP_RCMP:
            begin
                if (rpw_reg <= 66'(x_reg))
                begin
                    r_reg <= cand;
                end
                if (bit_reg == 5'd0)
                begin
                    dist_reg[sel_reg] <= (rpw_reg <= 66'(x_reg))
                        ? {16'd0, cand, 8'd0} : {16'd0, r_reg, 8'd0};
                end
                else
                begin
                    bit_reg <= bit_reg - 5'd1;
                end
            end
            tml_pkg::OP_LOSS:
            begin
                loss_reg <= loss_raw[57] ? 57'd0 : loss_raw[56:0];
            end
            tml_pkg::OP_DIVINIT:
            begin
                quo_reg     <= total_reg;
                rem_reg     <= 16'd0;
                div_cnt_reg <= 6'd47;
            end
            tml_pkg::OP_DIVSTEP:
            begin
                if (trial >= {1'b0, nb_eff})
                begin
                    rem_reg <= 16'(trial - {1'b0, nb_eff});
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial[15:0];
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg - 6'd1;
            end
            default:
            begin
                rsq_reg <= rsq_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i] <= 64'd0;
            end
            elem_reg  <= '0;
            row_reg   <= 16'd0;
            sel_reg   <= 2'd0;
            total_reg <= 48'd0;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                tml_pkg::OP_ACC:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i] <= sum_next[i];
                    end
                    if (status.row_end)
                    begin
                        elem_reg <= '0;
                        sel_reg  <= 2'd0;
                    end
                    else
                    begin
                        elem_reg <= elem_reg + 1'b1;
                    end
                end
                tml_pkg::OP_DNEXT:
                begin
                    sel_reg <= sel_reg + 2'd1;
                end
                tml_pkg::OP_TOTAL:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        sum_reg[i] <= 64'd0;
                    end
                    total_reg <= (total_sum > 58'(tml_pkg::TOTAL_CAP))
                        ? tml_pkg::TOTAL_CAP : total_sum[47:0];
                    last_reg  <= (17'(row_reg) + 17'd1) >= 17'(nb_eff);
                end
                tml_pkg::OP_ADV:
                begin
                    row_reg <= row_reg + 16'd1;
                end
                default:
                begin
                    sel_reg <= sel_reg;
                end
            endcase
            if (cmd.emit)
            begin
                if (last_reg)
                begin
                    row_reg   <= 16'd0;
                    total_reg <= 48'd0;
                end
                else
                begin
                    row_reg <= row_reg + 16'd1;
                end
            end
        end
    end

    always_comb
    begin
        if (mode_reg == tml_pkg::MODE_NONE)
        begin
            emit_value = (loss_reg[56:32] != 25'd0) ? 32'hFFFF_FFFF : loss_reg[31:0];
        end
        else if (mode_reg == tml_pkg::MODE_MEAN)
        begin
            emit_value = (quo_reg[47:32] != 16'd0) ? 32'hFFFF_FFFF : quo_reg[31:0];
        end
        else
        begin
            emit_value = (total_reg[47:32] != 16'd0) ? 32'hFFFF_FFFF : total_reg[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            loss_out_reg <= emit_value;
            row_out_reg  <= row_reg;
            done_out_reg <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign loss_value = loss_out_reg;
    assign row_index  = row_out_reg;
    assign batch_done = done_out_reg;

    always_comb
    begin
        status.row_end   = (32'(elem_reg) + 32'd1) >= dim_eff;
        status.order_one = (p_eff == 3'd1);
        status.bit_zero  = (bit_reg == 5'd0);
        status.sel_last  = (sel_reg == 2'd2);
        status.last_row  = last_reg;
        status.mode_none = (mode_reg == tml_pkg::MODE_NONE);
        status.mode_mean = (mode_reg == tml_pkg::MODE_MEAN);
        status.div_done  = (div_cnt_reg == 6'd0);
        status.out_free  = !out_valid_reg || !out_stall;
    end

endmodule
